// ===== rtl/core/sacl_pkg.sv =====
package sacl_pkg;

  localparam int ADDR_W         = 64;
  localparam int TAG_W          = 64;
  localparam int SET_RAW_W      = 6;
  localparam int WAY_OUT_W      = 2;
  localparam int SET_OUT_W      = 6;

  localparam int DEF_WAYS       = 4;
  localparam int DEF_SETS       = 64;
  localparam int DEF_STAMP_BITS = 32;

  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS     = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS   = 2'd2;
  localparam logic [1:0] REG_REPLACE_MODE = 2'd3;

  localparam logic MODE_LRU  = 1'b0;
  localparam logic MODE_FIFO = 1'b1;

  localparam logic [6:0] MAX_ADDRESS_BITS = 7'd64;
  localparam logic [2:0] MAX_SET_BITS     = 3'd6;

  typedef struct packed {
    logic [6:0] address_bits;
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic       replace_mode;
  } cfg_t;

endpackage

// ===== rtl/core/sacl_in_if.sv =====
interface sacl_in_if;
  logic                         valid;
  logic                         ready;
  logic [sacl_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// ===== rtl/core/sacl_out_if.sv =====
interface sacl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [sacl_pkg::WAY_OUT_W-1:0]  way_index;
  logic                            evicted;
  logic [sacl_pkg::SET_OUT_W-1:0]  set_index;

  modport source (output valid, output hit, output way_index, output evicted,
                  output set_index, input ready);
  modport sink (input valid, input hit, input way_index, input evicted,
                input set_index, output ready);
endinterface

// ===== rtl/core/sacl_ram.sv =====
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sacl_cfg.sv =====
module sacl_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]   paddr,
  input  logic [sacl_pkg::PDATA_W-1:0]   pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output sacl_pkg::cfg_t                 cfg
);

  sacl_pkg::cfg_t cfg_r;
  sacl_pkg::cfg_t cfg_nxt;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[sacl_pkg::PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        sacl_pkg::REG_ADDRESS_BITS: cfg_nxt.address_bits = pwdata[6:0];
        sacl_pkg::REG_SET_BITS:     cfg_nxt.set_bits     = pwdata[2:0];
        sacl_pkg::REG_BLOCK_BITS:   cfg_nxt.block_bits   = pwdata[5:0];
        sacl_pkg::REG_REPLACE_MODE: cfg_nxt.replace_mode = pwdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_bits <= sacl_pkg::MAX_ADDRESS_BITS;
      cfg_r.set_bits     <= '0;
      cfg_r.block_bits   <= '0;
      cfg_r.replace_mode <= sacl_pkg::MODE_LRU;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      sacl_pkg::REG_ADDRESS_BITS: prdata = sacl_pkg::PDATA_W'(cfg_r.address_bits);
      sacl_pkg::REG_SET_BITS:     prdata = sacl_pkg::PDATA_W'(cfg_r.set_bits);
      sacl_pkg::REG_BLOCK_BITS:   prdata = sacl_pkg::PDATA_W'(cfg_r.block_bits);
      sacl_pkg::REG_REPLACE_MODE: prdata = sacl_pkg::PDATA_W'(cfg_r.replace_mode);
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/sacl_split.sv =====
module sacl_split #(
  parameter int SETS   = sacl_pkg::DEF_SETS,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  sacl_pkg::cfg_t                 cfg,
  input  logic [sacl_pkg::ADDR_W-1:0]    address,
  output logic [SET_W-1:0]               set_idx,
  output logic [sacl_pkg::TAG_W-1:0]     tag
);

  localparam int SET_TBL_N = 2 ** sacl_pkg::SET_RAW_W;

  logic [6:0]                       abits;
  logic [2:0]                       sbits;
  logic [sacl_pkg::ADDR_W-1:0]      amask;
  logic [sacl_pkg::ADDR_W-1:0]      addr;
  logic [sacl_pkg::ADDR_W-1:0]      addr_sh;
  logic [sacl_pkg::SET_RAW_W-1:0]   smask;
  logic [sacl_pkg::SET_RAW_W-1:0]   set_raw;
  logic [6:0]                       upper;
  logic [SET_W-1:0]                 set_tbl [SET_TBL_N];

  assign abits = (cfg.address_bits > sacl_pkg::MAX_ADDRESS_BITS) ?
                 sacl_pkg::MAX_ADDRESS_BITS : cfg.address_bits;
  assign sbits = (cfg.set_bits > sacl_pkg::MAX_SET_BITS) ?
                 sacl_pkg::MAX_SET_BITS : cfg.set_bits;

  // a clamped width of 64 keeps every bit
  assign amask = abits[6] ? '1 : ((64'd1 << abits[5:0]) - 64'd1);
  assign addr  = address & amask;

  assign addr_sh = addr >> cfg.block_bits;
  assign smask   = sacl_pkg::SET_RAW_W'((7'd1 << sbits) - 7'd1);
  assign set_raw = addr_sh[sacl_pkg::SET_RAW_W-1:0] & smask;

  assign upper = 7'(cfg.block_bits) + 7'(sbits);
  assign tag   = (upper >= 7'd64) ? '0 : (addr >> upper[5:0]);

  // set index folded into the set count
  for (genvar g = 0; g < SET_TBL_N; g++) begin : g_set_tbl
    assign set_tbl[g] = SET_W'(g % SETS);
  end

  assign set_idx = set_tbl[set_raw];

endmodule

// ===== rtl/core/set_assoc_cache_lookup_core.sv =====
// flow: an accepted transaction goes through the prep and look states, the scan
//   state over the remaining ways when a valid line is replaced, and the write state,
//   which registers its result; no input is accepted until the read, decide and
//   write-back pass over the line memory ends, and write-back waits on a stalled output
// reset: synchronous, active low; the line memory is then cleared one set per cycle,
//   and no input is accepted until every set is cleared
module set_assoc_cache_lookup_core #(
  parameter int WAYS       = sacl_pkg::DEF_WAYS,
  parameter int SETS       = sacl_pkg::DEF_SETS,
  parameter int STAMP_BITS = sacl_pkg::DEF_STAMP_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sacl_in_if.sink                       in_ch,
  sacl_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]  paddr,
  input  logic [sacl_pkg::PDATA_W-1:0]  pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W  = sacl_pkg::TAG_W;
  localparam int LINE_W = 1 + TAG_W + STAMP_BITS;
  localparam int ROW_W  = WAYS * LINE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;

  sacl_pkg::cfg_t cfg;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [SET_W-1:0]              clr_addr_r;
  logic [STAMP_BITS-1:0]         count_r;
  logic [sacl_pkg::ADDR_W-1:0]   addr_r;
  logic [TAG_W-1:0]              tag_r;
  logic [SET_W-1:0]              set_r;
  logic [WAY_W-1:0]              way_r;
  logic [WAY_W-1:0]              scan_r;
  logic [STAMP_BITS-1:0]         best_r;
  logic                          hit_r;
  logic                          evict_r;

  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [sacl_pkg::WAY_OUT_W-1:0] out_way_r;
  logic                          out_evict_r;
  logic [sacl_pkg::SET_OUT_W-1:0] out_set_r;

  logic [SET_W-1:0]              sp_set;
  logic [TAG_W-1:0]              sp_tag;

  logic                          ram_wr_en;
  logic [SET_W-1:0]              ram_wr_addr;
  logic [ROW_W-1:0]              ram_wr_data;
  logic [ROW_W-1:0]              row;
  logic [ROW_W-1:0]              new_row;
  logic [LINE_W-1:0]             new_line;

  logic                          line_vld   [WAYS];
  logic [TAG_W-1:0]              line_tag   [WAYS];
  logic [STAMP_BITS-1:0]         line_stamp [WAYS];
  logic [WAYS-1:0]               hit_vec;
  logic [WAYS-1:0]               inv_vec;
  logic [WAY_W-1:0]              hit_way;
  logic [WAY_W-1:0]              inv_way;
  logic                          hit_any;
  logic                          inv_any;
  logic [STAMP_BITS-1:0]         scan_stamp;
  logic [STAMP_BITS-1:0]         old_stamp;
  logic                          scan_last;
  logic                          slot_free;
  logic                          write_done;
  logic                          in_fire;

  sacl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sacl_split #(.SETS(SETS)) u_split (
    .cfg     (cfg),
    .address (addr_r),
    .set_idx (sp_set),
    .tag     (sp_tag)
  );

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_lines (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (state_r == S_PREP),
    .rd_addr (sp_set),
    .rd_data (row)
  );

  // one row holds every way of a set: {valid, tag, stamp} per way
  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign line_stamp[w] = row[w*LINE_W +: STAMP_BITS];
    assign line_tag[w]   = row[w*LINE_W + STAMP_BITS +: TAG_W];
    assign line_vld[w]   = row[w*LINE_W + LINE_W - 1];
    assign hit_vec[w]    = line_vld[w] && (line_tag[w] == tag_r);
    assign inv_vec[w]    = !line_vld[w];
  end

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
    end
  end

  assign hit_any    = |hit_vec;
  assign inv_any    = |inv_vec;
  assign scan_stamp = line_stamp[scan_r];
  assign old_stamp  = line_stamp[way_r];
  assign scan_last  = (scan_r == WAY_W'(WAYS - 1));

  assign in_fire    = in_ch.valid && (state_r == S_IDLE);
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign write_done = (state_r == S_WRITE) && slot_free;

  // fifo hits keep the fill stamp
  assign new_line = {1'b1, tag_r,
                     (hit_r && (cfg.replace_mode == sacl_pkg::MODE_FIFO)) ? old_stamp : count_r};

  always_comb begin
    new_row = row;
    new_row[way_r*LINE_W +: LINE_W] = new_line;
  end

  assign ram_wr_en   = (state_r == S_CLEAR) || write_done;
  assign ram_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : set_r;
  assign ram_wr_data = (state_r == S_CLEAR) ? '0 : new_row;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == SET_W'(SETS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_LOOK;
      S_LOOK: begin
        if (hit_any || inv_any || (WAYS == 1)) state_nxt = S_WRITE;
        else state_nxt = S_SCAN;
      end
      S_SCAN:  if (scan_last) state_nxt = S_WRITE;
      S_WRITE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + SET_W'(1);
      end
      if (write_done) begin
        count_r     <= count_r + STAMP_BITS'(1);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r <= in_ch.address;
    end
    if (state_r == S_PREP) begin
      tag_r <= sp_tag;
      set_r <= sp_set;
    end
    if (state_r == S_LOOK) begin
      scan_r <= WAY_W'(1);
      best_r <= line_stamp[0];
      if (hit_any) begin
        way_r   <= hit_way;
        hit_r   <= 1'b1;
        evict_r <= 1'b0;
      end else if (inv_any) begin
        way_r   <= inv_way;
        hit_r   <= 1'b0;
        evict_r <= 1'b0;
      end else begin
        way_r   <= '0;
        hit_r   <= 1'b0;
        evict_r <= 1'b1;
      end
    end
    if (state_r == S_SCAN) begin
      // strict compare keeps the lowest way on a tie
      if (scan_stamp < best_r) begin
        best_r <= scan_stamp;
        way_r  <= scan_r;
      end
      scan_r <= scan_r + WAY_W'(1);
    end
    if (write_done) begin
      out_hit_r   <= hit_r;
      out_way_r   <= sacl_pkg::WAY_OUT_W'(way_r);
      out_evict_r <= evict_r;
      out_set_r   <= sacl_pkg::SET_OUT_W'(set_r);
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.way_index = out_way_r;
  assign out_ch.evicted   = out_evict_r;
  assign out_ch.set_index = out_set_r;

endmodule

// ===== rtl/core/sacl_checker.sv =====
module sacl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic                            out_evicted,
  input logic [sacl_pkg::WAY_OUT_W-1:0]  out_way_index,
  input logic [sacl_pkg::SET_OUT_W-1:0]  out_set_index
);

  // a hit never replaces a line
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit reported together with an eviction");

  // one transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a lookup is in flight");

  // the line memory clear follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input ready before the line memory was cleared");

  // a new result appears only from the write-back cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared outside a lookup");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_hit) && $stable(out_evicted) &&
       $stable(out_way_index) && $stable(out_set_index)))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lookup_core sacl_checker u_sacl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_hit       (out_ch.hit),
  .out_evicted   (out_ch.evicted),
  .out_way_index (out_ch.way_index),
  .out_set_index (out_ch.set_index)
);
